/* hw/rtl/iirdf1_pkg.sv */
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants for the direct form I recursive filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int IDX_W      = 4;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_W     = SAMPLE_W + COEF_W;

  localparam int S_TDATA_W  = 56;
  localparam int M_TDATA_W  = 16;

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/iir_direct_form_one_filter.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I recursive filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_axis   in         tuser: func; tdata: sample_in, coef_index, coef_value
//  m_axis   out        tuser: saturated; tdata: sample_out
//
// A sample is accepted in the idle state, then the single multiplier steps
// through all products, one per cycle, the product register is drained,
// and the result is truncated, saturated and stored.
// Reset clears the coefficients, both histories and all control state.
// The block stays busy while a finished sample waits on a stalled m_axis.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter #(
  parameter int ORDER = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits from low: sample_in[15:0], coef_index[19:16], coef_value[51:20], zero fill.
  input  logic [iirdf1_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // Bit 0: func.
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits from low: sample_out[15:0].
  output logic [iirdf1_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Bit 0: saturated.
  output logic                               m_axis_tuser
);

  import iirdf1_pkg::*;

  localparam int COEF_N = 2 * ORDER + 1;
  localparam int CI_W   = $clog2(COEF_N);
  localparam int HIST_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ACC_W  = PROD_W + $clog2(COEF_N);
  localparam int TOP    = FRAC_BITS + SAMPLE_W - 1;

  state_t state;
  state_t state_next;

  logic signed [COEF_W-1:0]   coef_tbl [COEF_N];
  logic signed [SAMPLE_W-1:0] in_hist  [ORDER];
  logic signed [SAMPLE_W-1:0] out_hist [ORDER];

  logic [CI_W-1:0]            step;
  logic signed [SAMPLE_W-1:0] x_reg;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_valid;
  logic signed [ACC_W-1:0]    acc;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sat;

  logic                       in_fire;
  logic                       fire_sample;
  logic                       fire_coef;
  logic                       issue;
  logic                       finish_ok;

  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_idx;
  logic signed [COEF_W-1:0]   in_coef;

  logic [CI_W-1:0]            hidx_full;
  logic [HIST_W-1:0]          hidx;
  logic signed [SAMPLE_W-1:0] operand;

  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [SAMPLE_W-1:0] y_val;

  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_idx    = s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
  assign in_coef   = s_axis_tdata[SAMPLE_W+IDX_W+COEF_W-1:SAMPLE_W+IDX_W];

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign fire_sample = in_fire && (s_axis_tuser == FUNC_FILTER);
  assign fire_coef   = in_fire && (s_axis_tuser == FUNC_COEF);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sample;
  assign m_axis_tuser  = out_sat;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fire_sample) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (step == CI_W'(COEF_N - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    finish_ok     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_MAC: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        finish_ok = !out_valid || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (step <= CI_W'(ORDER)) begin
      hidx_full = step - CI_W'(1);
    end else begin
      hidx_full = step - CI_W'(ORDER + 1);
    end
    hidx = hidx_full[HIST_W-1:0];
    if (step == '0) begin
      operand = x_reg;
    end else if (step <= CI_W'(ORDER)) begin
      operand = in_hist[hidx];
    end else begin
      operand = out_hist[hidx];
    end
  end

  assign sat_hi = !acc[ACC_W-1] && (|acc[ACC_W-2:TOP]);
  assign sat_lo = acc[ACC_W-1] && !(&acc[ACC_W-2:TOP]);

  always_comb begin
    priority if (sat_hi) begin
      y_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      y_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_val = acc[TOP:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < COEF_N; i++) begin
        coef_tbl[i] <= '0;
      end
      for (int i = 0; i < ORDER; i++) begin
        in_hist[i]  <= '0;
        out_hist[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (fire_coef && (32'(in_idx) < COEF_N)) begin
        coef_tbl[CI_W'(in_idx)] <= in_coef;
      end

      if (fire_sample) begin
        step <= '0;
      end else if (issue) begin
        step <= step + CI_W'(1);
      end

      prod_valid <= issue;

      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (finish_ok) begin
        out_valid <= 1'b1;
        for (int i = ORDER - 1; i > 0; i--) begin
          in_hist[i]  <= in_hist[i-1];
          out_hist[i] <= out_hist[i-1];
        end
        in_hist[0]  <= x_reg;
        out_hist[0] <= y_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_sample) begin
      x_reg <= in_sample;
      acc   <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
    if (issue) begin
      prod <= coef_tbl[step] * operand;
    end
    if (finish_ok) begin
      out_sample <= y_val;
      out_sat    <= sat_hi || sat_lo;
    end
  end

endmodule
